// File: rtl/quad_grid_nodal_area_core_defines.svh
// Assertion macros shared by the checker of the nodal area core.
// Used by rtl/qgna_chk.sv; needs nothing else.
`ifndef QUAD_GRID_NODAL_AREA_CORE_DEFINES_SVH
`define QUAD_GRID_NODAL_AREA_CORE_DEFINES_SVH

// Same-cycle implication.
`define QGNA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define QGNA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/qgna_pkg.sv
// Types, constants and helpers of the quad grid nodal area core.
// Used by rtl/qgna_shares.sv and rtl/quad_grid_nodal_area_core.sv.
`timescale 1ns / 1ps
package qgna_pkg;

  localparam int COORD_BITS = 24;
  localparam int AREA_BITS  = 48;
  localparam int INDEX_BITS = 26;
  localparam int ROWS_BITS  = 16;
  localparam int COLS_BITS  = 11;
  localparam int CFG_BITS   = 16;
  localparam int CFG_IDX_BITS = 1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_ROWS = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COLS = 1'd1;

  localparam int DIFF_BITS  = COORD_BITS + 2;
  localparam int CHUNK_BITS = 27;
  localparam int OPA_BITS   = CHUNK_BITS + 1;
  localparam int OPB_BITS   = 36;
  localparam int PROD_BITS  = OPA_BITS + OPB_BITS;
  localparam int WIDE_BITS  = 3 * CHUNK_BITS;
  localparam int ACC_BITS   = 112;
  localparam int A0_BITS    = 54;
  localparam int DET_BITS   = 72;
  localparam int GAUSS_SHIFT = 16;
  localparam int SUM_SHIFT  = 54;

  localparam logic signed [OPB_BITS-1:0] GAUSS_Q = 36'sd37837;
  localparam logic signed [OPB_BITS-1:0] W_PP    = 36'sd10685977129;
  localparam logic signed [OPB_BITS-1:0] W_PM    = 36'sd2863328727;
  localparam logic signed [OPB_BITS-1:0] W_MM    = 36'sd767234601;

  // Corner k sits at +1 in xi (eta) where bit k is set.
  localparam logic [3:0] CORNER_XI  = 4'b0110;
  localparam logic [3:0] CORNER_ETA = 4'b1100;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [AREA_BITS-1:0] area_t;
  typedef logic [INDEX_BITS-1:0] index_t;

  localparam area_t AREA_MAX = '1;

  function automatic area_t sat_add(area_t a, area_t b);
    logic [AREA_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[AREA_BITS] ? AREA_MAX : s[AREA_BITS-1:0];
  endfunction

endpackage

// File: rtl/qgna_shares.sv
// Corner shares of one bilinear cell by 2x2 Gauss quadrature, computed
// on one shared multiplier and accumulator. Depends on rtl/qgna_pkg.sv.
`timescale 1ns / 1ps
module qgna_shares
  import qgna_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  coord_t px [4],
  input  coord_t py [4],
  output logic   done,
  output area_t  share [4]
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MAC   = 3'd1;
  localparam logic [2:0] ST_DSUM  = 3'd2;
  localparam logic [2:0] ST_ESUM  = 3'd3;
  localparam logic [2:0] ST_SHARE = 3'd4;

  logic [2:0] state;
  logic [3:0] step;
  logic [1:0] corner, term, chunk;

  logic signed [DIFF_BITS-1:0] c1, c2, c3, d1, d2, d3;
  logic signed [A0_BITS-1:0]   a0;
  logic signed [WIDE_BITS-1:0] a1, a2;
  logic signed [DET_BITS-1:0]  gp, gq;
  logic [WIDE_BITS-1:0] dabs [4];
  logic [WIDE_BITS-1:0] e02, e13;
  logic signed [ACC_BITS-1:0] acc;

  logic signed [OPA_BITS-1:0] op_a;
  logic signed [OPB_BITS-1:0] op_b;
  logic signed [PROD_BITS-1:0] prod;
  logic signed [ACC_BITS-1:0] prod_ext, addend, acc_base, acc_next, rnd;
  logic [1:0] chk, dsel;
  logic use_wide, clr, sub;
  logic [WIDE_BITS-1:0] wide;
  logic [WIDE_BITS-1:0] dabs_next [4];
  area_t share_next;

  always_comb begin
    op_a = '0;
    op_b = '0;
    chk = 2'd0;
    use_wide = 1'b0;
    clr = 1'b0;
    sub = 1'b0;
    wide = '0;
    dsel = (term == 2'd2) ? (corner ^ 2'd2) : corner;
    case (state)
      ST_MAC: begin
        case (step)
          4'd0: begin op_a = OPA_BITS'(c1); op_b = OPB_BITS'(d2); clr = 1'b1; end
          4'd1: begin op_a = OPA_BITS'(c2); op_b = OPB_BITS'(d1); sub = 1'b1; end
          4'd2: begin op_a = OPA_BITS'(c1); op_b = OPB_BITS'(d3); clr = 1'b1; end
          4'd3: begin op_a = OPA_BITS'(c3); op_b = OPB_BITS'(d1); sub = 1'b1; end
          4'd4: begin op_a = OPA_BITS'(c3); op_b = OPB_BITS'(d2); clr = 1'b1; end
          4'd5: begin op_a = OPA_BITS'(c2); op_b = OPB_BITS'(d3); sub = 1'b1; end
          4'd6: begin use_wide = 1'b1; wide = a1; op_b = GAUSS_Q; clr = 1'b1; end
          4'd7: begin use_wide = 1'b1; wide = a1; op_b = GAUSS_Q; chk = 2'd1; end
          4'd8: begin use_wide = 1'b1; wide = a1; op_b = GAUSS_Q; chk = 2'd2; end
          4'd9: begin use_wide = 1'b1; wide = a2; op_b = GAUSS_Q; clr = 1'b1; end
          4'd10: begin use_wide = 1'b1; wide = a2; op_b = GAUSS_Q; chk = 2'd1; end
          4'd11: begin use_wide = 1'b1; wide = a2; op_b = GAUSS_Q; chk = 2'd2; end
          default: ;
        endcase
      end
      ST_SHARE: begin
        use_wide = 1'b1;
        chk = chunk;
        clr = (term == 2'd0) && (chunk == 2'd0);
        case (term)
          2'd0: begin wide = dabs[dsel]; op_b = W_PP; end
          2'd1: begin wide = corner[0] ? e02 : e13; op_b = W_PM; end
          default: begin wide = dabs[dsel]; op_b = W_MM; end
        endcase
      end
      default: ;
    endcase
    if (use_wide) begin
      case (chk)
        2'd0: op_a = {1'b0, wide[CHUNK_BITS-1:0]};
        2'd1: op_a = {1'b0, wide[2*CHUNK_BITS-1:CHUNK_BITS]};
        default: op_a = {wide[WIDE_BITS-1], wide[WIDE_BITS-1:2*CHUNK_BITS]};
      endcase
    end
  end

  always_comb begin
    prod = op_a * op_b;
    prod_ext = ACC_BITS'(prod);
    case (chk)
      2'd0: addend = prod_ext;
      2'd1: addend = prod_ext <<< CHUNK_BITS;
      default: addend = prod_ext <<< (2 * CHUNK_BITS);
    endcase
    acc_base = clr ? '0 : acc;
    acc_next = sub ? (acc_base - addend) : (acc_base + addend);
    rnd = acc_next + (ACC_BITS'(1) <<< (SUM_SHIFT - 1));
    share_next = (|rnd[ACC_BITS-1:SUM_SHIFT+AREA_BITS]) ? AREA_MAX
                 : rnd[SUM_SHIFT+AREA_BITS-1:SUM_SHIFT];
  end

  always_comb begin
    logic signed [DET_BITS-1:0] dval;
    logic [DET_BITS-1:0] mag;
    for (int k = 0; k < 4; k++) begin
      dval = (DET_BITS'(a0) <<< GAUSS_SHIFT)
           + (CORNER_XI[k] ? gp : -gp)
           + (CORNER_ETA[k] ? gq : -gq);
      mag = dval[DET_BITS-1] ? DET_BITS'(-dval) : DET_BITS'(dval);
      dabs_next[k] = WIDE_BITS'(mag);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step <= '0;
      corner <= '0;
      term <= '0;
      chunk <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_MAC;
            step <= '0;
          end
        end
        ST_MAC: begin
          if (step == 4'd11) begin
            state <= ST_DSUM;
          end else begin
            step <= step + 4'd1;
          end
        end
        ST_DSUM: state <= ST_ESUM;
        ST_ESUM: begin
          state <= ST_SHARE;
          corner <= '0;
          term <= '0;
          chunk <= '0;
        end
        ST_SHARE: begin
          if (chunk == 2'd2) begin
            chunk <= '0;
            if (term == 2'd2) begin
              term <= '0;
              corner <= corner + 2'd1;
              if (corner == 2'd3) begin
                state <= ST_IDLE;
                done <= 1'b1;
              end
            end else begin
              term <= term + 2'd1;
            end
          end else begin
            chunk <= chunk + 2'd1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          c1 <= DIFF_BITS'(px[1]) + DIFF_BITS'(px[2]) - DIFF_BITS'(px[0]) - DIFF_BITS'(px[3]);
          c2 <= DIFF_BITS'(px[2]) + DIFF_BITS'(px[3]) - DIFF_BITS'(px[0]) - DIFF_BITS'(px[1]);
          c3 <= DIFF_BITS'(px[0]) + DIFF_BITS'(px[2]) - DIFF_BITS'(px[1]) - DIFF_BITS'(px[3]);
          d1 <= DIFF_BITS'(py[1]) + DIFF_BITS'(py[2]) - DIFF_BITS'(py[0]) - DIFF_BITS'(py[3]);
          d2 <= DIFF_BITS'(py[2]) + DIFF_BITS'(py[3]) - DIFF_BITS'(py[0]) - DIFF_BITS'(py[1]);
          d3 <= DIFF_BITS'(py[0]) + DIFF_BITS'(py[2]) - DIFF_BITS'(py[1]) - DIFF_BITS'(py[3]);
        end
      end
      ST_MAC: begin
        acc <= acc_next;
        case (step)
          4'd1: a0 <= acc_next[A0_BITS-1:0];
          4'd3: a1 <= acc_next[WIDE_BITS-1:0];
          4'd5: a2 <= acc_next[WIDE_BITS-1:0];
          4'd8: gp <= acc_next[DET_BITS-1:0];
          4'd11: gq <= acc_next[DET_BITS-1:0];
          default: ;
        endcase
      end
      ST_DSUM: begin
        for (int k = 0; k < 4; k++) begin
          dabs[k] <= dabs_next[k];
        end
      end
      ST_ESUM: begin
        e02 <= dabs[0] + dabs[2];
        e13 <= dabs[1] + dabs[3];
      end
      ST_SHARE: begin
        acc <= acc_next;
        if ((term == 2'd2) && (chunk == 2'd2)) begin
          share[corner] <= share_next;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/quad_grid_nodal_area_core.sv
// Top level of the quad grid nodal area core: counters, row memories,
// result queue and output register. Depends on rtl/qgna_pkg.sv, rtl/qgna_shares.sv.
`timescale 1ns / 1ps
// Nodes of a structured grid enter on the s_ channel in row-major order,
// one (x, y) pair per request. Each finished node leaves on the m_ channel
// as its index and lumped area; m_tlast marks the last result caused by
// a request and m_tuser marks the final node of the grid.
// rows and cols are written through cfg_we, cfg_index and cfg_data; the user
// must write them only while the block is idle, which the block itself does
// not enforce. Every write restarts the grid at node 0. The block works on
// one request at a time. A request that closes a cell waits for the cell
// unit, which runs 50 steps on a single 28x36 multiplier; any other request
// skips it. The results of a request then leave one by one. Coordinates of
// the row above and the area accumulators of two rows live in single-port
// memories with a registered read; the left neighbors are carried in registers.
// Reset clears the counters and the output valid flag and sets rows and cols
// to 2; the memories need no clearing pass. When the receiver stalls, the
// result in the output register holds and no further request is taken
// until all results of the current one have entered the output register.
module quad_grid_nodal_area_core
  import qgna_pkg::*;
#(
  parameter int MAX_COLS = 1024
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [47:0]             s_tdata,   // x_coord[23:0], y_coord[47:24]
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [79:0]             m_tdata,   // node_index[25:0], area[73:26], zero
  output logic                    m_tlast,
  output logic [0:0]              m_tuser    // mesh_end[0]
);

  localparam int COL_BITS = $clog2(MAX_COLS);
  localparam int NC_BITS  = $clog2(MAX_COLS + 1);
  localparam logic [NC_BITS-1:0] NC_MAX = NC_BITS'(MAX_COLS);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_READ   = 3'd1;
  localparam logic [2:0] ST_LOAD   = 3'd2;
  localparam logic [2:0] ST_CALC   = 3'd3;
  localparam logic [2:0] ST_WRCUR  = 3'd4;
  localparam logic [2:0] ST_WRLEFT = 3'd5;
  localparam logic [2:0] ST_EMIT   = 3'd6;

  logic [2:0] state;
  logic [ROWS_BITS-1:0] rows, row_count, nr;
  logic [COLS_BITS-1:0] cols;
  logic [COL_BITS-1:0] col_count;
  logic [NC_BITS-1:0] nc;
  index_t node_idx;
  logic bank;

  coord_t in_x, in_y;
  coord_t up_x, up_y, left_x, left_y;
  area_t hold_prv, hold_cur, left_area;
  logic [3:0] em_vld;
  index_t em_idx [4];
  area_t em_area [4];
  logic final_item;

  logic [2*COORD_BITS-1:0] coord_mem [MAX_COLS];
  logic [2*COORD_BITS-1:0] coord_rd;
  area_t area_mem [2*MAX_COLS];
  area_t area_rd;
  logic area_we;
  logic [COL_BITS:0] area_waddr;
  area_t area_wdata;

  logic degen, last_col, last_row, is_cell, final_c;
  logic start, done;
  coord_t px [4], py [4];
  area_t share [4];
  area_t sh [4];
  area_t e0, new_prv, e2, e3;
  index_t nci;
  logic [1:0] pick;
  logic [3:0] rest;
  logic out_free;
  logic out_load;

  index_t out_idx;
  area_t out_area;
  logic out_mesh;

  always_comb begin
    if (cols == '0) begin
      nc = NC_BITS'(1);
    end else if (32'(cols) > MAX_COLS) begin
      nc = NC_MAX;
    end else begin
      nc = NC_BITS'(cols);
    end
    nr = (rows == '0) ? ROWS_BITS'(1) : rows;
    degen = (nr < ROWS_BITS'(2)) || (nc < NC_BITS'(2));
    last_col = (NC_BITS'(col_count) + NC_BITS'(1)) == nc;
    last_row = row_count == (nr - ROWS_BITS'(1));
    final_c = last_col && last_row;
    is_cell = !degen && (row_count != '0) && (col_count != '0);
    nci = INDEX_BITS'(nc);
  end

  assign start = (state == ST_LOAD) && is_cell;
  assign px[0] = up_x;
  assign py[0] = up_y;
  assign px[1] = coord_rd[COORD_BITS-1:0];
  assign py[1] = coord_rd[2*COORD_BITS-1:COORD_BITS];
  assign px[2] = in_x;
  assign py[2] = in_y;
  assign px[3] = left_x;
  assign py[3] = left_y;

  qgna_shares u_shares (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .px    (px),
    .py    (py),
    .done  (done),
    .share (share)
  );

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sh[k] = is_cell ? share[k] : '0;
    end
    e0 = sat_add(hold_prv, sh[0]);
    new_prv = sat_add(area_rd, sh[1]);
    e2 = sat_add(hold_cur, sh[3]);
    e3 = sh[2];
  end

  always_comb begin
    area_we = 1'b0;
    area_waddr = {bank, col_count};
    area_wdata = e3;
    if (state == ST_WRCUR) begin
      area_we = 1'b1;
    end else if ((state == ST_WRLEFT) && is_cell) begin
      area_we = 1'b1;
      area_waddr = {bank, col_count - COL_BITS'(1)};
      area_wdata = left_area;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      coord_rd <= coord_mem[col_count];
    end
    if (state == ST_LOAD) begin
      coord_mem[col_count] <= {in_y, in_x};
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      area_rd <= area_mem[{~bank, col_count}];
    end
    if (area_we) begin
      area_mem[area_waddr] <= area_wdata;
    end
  end

  always_comb begin
    pick = 2'd0;
    for (int i = 3; i >= 0; i--) begin
      if (em_vld[i]) begin
        pick = 2'(i);
      end
    end
    rest = em_vld & ~(4'b0001 << pick);
    out_free = !m_tvalid || m_tready;
    out_load = (state == ST_EMIT) && (em_vld != '0) && out_free;
  end

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rows <= ROWS_BITS'(2);
      cols <= COLS_BITS'(2);
      row_count <= '0;
      col_count <= '0;
      node_idx <= '0;
      bank <= 1'b0;
      em_vld <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_READ;
          end
        end
        ST_READ: state <= ST_LOAD;
        ST_LOAD: state <= is_cell ? ST_CALC : ST_WRCUR;
        ST_CALC: begin
          if (done) begin
            state <= ST_WRCUR;
          end
        end
        ST_WRCUR: begin
          state <= ST_WRLEFT;
          em_vld <= {degen || (is_cell && final_c), is_cell && last_row,
                     is_cell && last_col, is_cell};
        end
        ST_WRLEFT: begin
          state <= ST_EMIT;
          if (last_col) begin
            col_count <= '0;
            bank <= ~bank;
            row_count <= last_row ? '0 : row_count + ROWS_BITS'(1);
          end else begin
            col_count <= col_count + COL_BITS'(1);
          end
          node_idx <= final_c ? '0 : node_idx + INDEX_BITS'(1);
        end
        ST_EMIT: begin
          if (em_vld == '0) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            em_vld <= rest;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (cfg_we) begin
        case (cfg_index)
          CFG_ROWS: rows <= cfg_data[ROWS_BITS-1:0];
          CFG_COLS: cols <= cfg_data[COLS_BITS-1:0];
          default: ;
        endcase
        row_count <= '0;
        col_count <= '0;
        node_idx <= '0;
        bank <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        in_x <= s_tdata[COORD_BITS-1:0];
        in_y <= s_tdata[2*COORD_BITS-1:COORD_BITS];
      end
      ST_LOAD: begin
        up_x <= coord_rd[COORD_BITS-1:0];
        up_y <= coord_rd[2*COORD_BITS-1:COORD_BITS];
        left_x <= in_x;
        left_y <= in_y;
      end
      ST_WRCUR: begin
        hold_prv <= new_prv;
        hold_cur <= e3;
        left_area <= e2;
        em_idx[0] <= node_idx - nci - INDEX_BITS'(1);
        em_idx[1] <= node_idx - nci;
        em_idx[2] <= node_idx - INDEX_BITS'(1);
        em_idx[3] <= node_idx;
        em_area[0] <= e0;
        em_area[1] <= new_prv;
        em_area[2] <= e2;
        em_area[3] <= e3;
        final_item <= final_c;
      end
      ST_EMIT: begin
        if (out_load) begin
          out_idx <= em_idx[pick];
          out_area <= em_area[pick];
          m_tlast <= (rest == '0);
          out_mesh <= (rest == '0) && final_item;
        end
      end
      default: ;
    endcase
  end

  assign m_tdata = {6'd0, out_area, out_idx};
  assign m_tuser = out_mesh;

endmodule

// File: rtl/qgna_chk.sv
// Port-level checker of the quad grid nodal area core, bound to the top.
// Depends on rtl/quad_grid_nodal_area_core_defines.svh and the top level.
`timescale 1ns / 1ps
`include "quad_grid_nodal_area_core_defines.svh"
module qgna_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata,
  input logic        m_tlast,
  input logic [0:0]  m_tuser
);

  `QGNA_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "Stalled result changed.")
  `QGNA_ASSERT_IMPL(a_mesh_last, clk, rst, m_tvalid && m_tuser[0], m_tlast, "Grid end without last.")
  `QGNA_ASSERT_NEXT(a_one_req, clk, rst, s_tvalid && s_tready, !s_tready, "Request taken while busy.")
  `QGNA_ASSERT_IMPL(a_pad_zero, clk, rst, m_tvalid, m_tdata[79:74] == 6'd0, "Padding bits set.")
  `QGNA_ASSERT_NEXT(a_rst_clear, clk, 1'b0, rst, !m_tvalid && s_tready, "Reset left a result.")

endmodule

bind quad_grid_nodal_area_core qgna_chk u_qgna_chk (.*);
